// ----- hdl/line_pattern_cut_filter_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LINE_PATTERN_CUT_FILTER_MACROS_SVH
`define LINE_PATTERN_CUT_FILTER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define LPCF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define LPCF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ----- hdl/lpcf_pkg.sv -----
// Constants and register codes for the line pattern cut filter.
package lpcf_pkg;
   localparam int LINE_BYTES    = 64;
   localparam int PATTERN_BYTES = 8;

   localparam int FILL_W = $clog2(LINE_BYTES + 1);
   localparam int ADDR_W = $clog2(LINE_BYTES);
   localparam int WIN_W  = 8 * PATTERN_BYTES;
   localparam int PSEL_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int PLEN_W = 4;
   localparam int PAT_W  = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd2;

   typedef logic [7:0] byte_type;
endpackage

// ----- hdl/lpcf_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
module lpcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/line_pattern_cut_filter.sv -----
// Line pattern cut filter: per-line substring search with suffix/prefix cut.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall| req_in_byte
//  rsp     | out       | rsp_valid/rsp_stall| rsp_out_byte, rsp_line_last
//  csr     | in        | csr_valid/csr_ready| csr_index, csr_data
//
// A byte that gives at most one result is accepted at once. A matching byte
// holds the input while its bytes go out, one per cycle while rsp_stall
// allows: the pattern bytes from the window register in suffix mode, the
// stored line from the line-buffer RAM in prefix mode (registered reads).
// A closing LF after a match holds the input while CR and LF go out.
// rsp_stall holds the output register and, through it, the emit sequencer.
// Synchronous reset clears control and sets the CSRs to defaults; the line
// RAM is not cleared, since only entries written in the current line are read.
module line_pattern_cut_filter
   import lpcf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_line_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PAT_W-1:0]     csr_data
);
   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
   localparam logic [ST_W-1:0] ST_WIN  = 3'd1;  // emit bytes from window
   localparam logic [ST_W-1:0] ST_RAM  = 3'd2;  // emit stored prefix
   localparam logic [ST_W-1:0] ST_CR   = 3'd3;
   localparam logic [ST_W-1:0] ST_LF   = 3'd4;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              match_ff, match_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [PSEL_W-1:0] k_ff, k_in;
   logic [FILL_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic              dv_ff, dv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   byte_type          rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // configuration registers
   logic [PAT_W-1:0]  pat_ff;
   logic [PLEN_W-1:0] plen_ff;
   logic              mode_ff;

   logic              ram_we, ram_re;
   byte_type          ram_rd_data;

   logic              out_free;
   logic [FILL_W-1:0] new_fill;
   logic [WIN_W-1:0]  new_win;
   logic [PLEN_W-1:0] eff_len;
   logic [PLEN_W-1:0] pidx;
   logic              hit;
   logic              consume;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= PLEN_W'(1);
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN: pat_ff  <= csr_data;
            CSR_LENGTH:  plen_ff <= csr_data[PLEN_W-1:0];
            CSR_MODE:    mode_ff <= csr_data[0];
            default:     ;
         endcase
      end
   end

   // Pattern length: zero acts as one, anything too long as the maximum.
   always_comb begin
      if (plen_ff == '0) begin
         eff_len = PLEN_W'(1);
      end else if (plen_ff > PLEN_W'(PATTERN_BYTES)) begin
         eff_len = PLEN_W'(PATTERN_BYTES);
      end else begin
         eff_len = plen_ff;
      end
   end

   assign new_fill = fill_ff + FILL_W'(1);
   assign new_win  = (win_ff << 8) | WIN_W'(req_in_byte);

   // Window byte k (newest at k=0) against pattern byte n-1-k.
   always_comb begin
      hit  = (new_fill >= FILL_W'(eff_len));
      pidx = '0;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         if (PLEN_W'(k) < eff_len) begin
            pidx = eff_len - PLEN_W'(1) - PLEN_W'(k);
            if (new_win[8*k +: 8] != pat_ff[8*pidx +: 8]) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      match_in     = match_ff;
      win_in       = win_ff;
      k_in         = k_ff;
      rd_ptr_in    = rd_ptr_ff;
      dv_in        = dv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      consume      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_in_byte == CHAR_LF) begin
                  fill_in  = '0;
                  match_in = 1'b0;
                  win_in   = '0;
                  if (match_ff) begin
                     state_in = ST_CR;
                  end
               end else if (fill_ff < FILL_W'(LINE_BYTES)) begin
                  ram_we  = 1'b1;
                  fill_in = new_fill;
                  win_in  = new_win;
                  if (match_ff) begin
                     // after the match, suffix mode passes each byte on
                     if (!mode_ff) begin
                        if (out_free) begin
                           rsp_valid_in = 1'b1;
                           rsp_byte_in  = req_in_byte;
                           rsp_last_in  = 1'b0;
                        end else begin
                           k_in     = '0;
                           state_in = ST_WIN;
                        end
                     end
                  end else if (hit) begin
                     match_in = 1'b1;
                     if (!mode_ff) begin
                        k_in     = PSEL_W'(eff_len - PLEN_W'(1));
                        state_in = ST_WIN;
                     end else begin
                        rd_ptr_in = '0;
                        dv_in     = 1'b0;
                        state_in  = ST_RAM;
                     end
                  end
               end
            end
         end
         ST_WIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = win_ff[8*k_ff +: 8];
               rsp_last_in  = 1'b0;
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff - PSEL_W'(1);
               end
            end
         end
         ST_RAM: begin
            // one read in flight; RAM output holds until the next read
            consume = dv_ff && out_free;
            if (consume) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ram_rd_data;
               rsp_last_in  = 1'b0;
            end
            if ((rd_ptr_ff != fill_ff) && (!dv_ff || out_free)) begin
               ram_re    = 1'b1;
               rd_ptr_in = rd_ptr_ff + FILL_W'(1);
               dv_in     = 1'b1;
            end else if (consume) begin
               dv_in = 1'b0;
            end
            if ((rd_ptr_ff == fill_ff) && (!dv_ff || consume)) begin
               state_in = ST_IDLE;
            end
         end
         ST_CR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CHAR_CR;
               rsp_last_in  = 1'b0;
               state_in     = ST_LF;
            end
         end
         ST_LF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CHAR_LF;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         match_ff     <= 1'b0;
         win_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         match_ff     <= match_in;
         win_ff       <= win_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rd_ptr_ff   <= rd_ptr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line buffer
   lpcf_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_line_last = rsp_last_ff;
endmodule

// ----- hdl/lpcf_checker.sv -----
// Port-level checker for the line pattern cut filter, bound to the top level.
`include "line_pattern_cut_filter_macros.svh"

module lpcf_checker
   import lpcf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_line_last
);
   logic     lf_open;
   logic     held_ff, held_in;
   byte_type prev_byte_ff, prev_byte_in;

   // LF with the line marker on the output
   assign lf_open      = rsp_valid && rsp_line_last;
   // output offered but not taken: the same transaction is still shown
   assign held_in      = rsp_valid && rsp_stall;
   assign prev_byte_in = rsp_out_byte;

   always_ff @(posedge clock) begin
      held_ff      <= held_in;
      prev_byte_ff <= prev_byte_in;
   end

   // a stalled transaction stays offered
   `LPCF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // the line marker only ever rides on an LF
   `LPCF_ASSERT(a_last_is_lf, clock, reset, lf_open |-> rsp_out_byte == CHAR_LF)

   // a freshly loaded LF carrying the marker follows a delivered CR
   `LPCF_ASSERT(a_cr_before_lf, clock, reset, lf_open && !held_ff |-> prev_byte_ff == CHAR_CR)

   // nothing is offered right after reset
   `LPCF_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid)
endmodule

bind line_pattern_cut_filter lpcf_checker u_lpcf_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the line pattern cut filter: directed table, then random phases.
module testbench
   import lpcf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Run shape
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 80;      // covers a prefix burst of a full line, plus CR LF
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 30;
   localparam int HOLD_PHASE   = 4;       // receiver holds off, input backs up
   localparam int PAUSE_PHASE  = 6;       // sender waits for all results mid-phase
   localparam int HOLD_CYCLES  = 400;

   // Index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int SEND_IDLE  [PHASES] = '{0, 82, 0, 7, 0, 82, 0, 7};
   localparam int RECV_STALL [PHASES] = '{0, 0, 82, 7, 0, 0, 82, 7};

   typedef struct packed {
      byte_type data;
      logic     last;
   } cut_byte_type;

   // Directed stimulus row. A typed row carries its own expected output (count
   // and bytes); other rows are checked against the predictor.
   typedef enum logic [0:0] {ROW_BYTE, ROW_CSR} row_kind_type;
   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [PAT_W-1:0]       data;
      logic [7:0]             reps;
      logic                   typed;
      logic [1:0]             n;
      byte_type               b0;
      byte_type               b1;
   } row_type;

   localparam int ROWS = 33;
   localparam row_type DIRECTED [ROWS] = '{
      // reset values: pattern 0x00, length 1, suffix mode
      '{ROW_BYTE, '0, 64'h00, 8'd1, 1'b1, 2'd1, 8'h00, 8'h00},     // hit at position 0
      '{ROW_BYTE, '0, 64'hFF, 8'd1, 1'b1, 2'd1, 8'hFF, 8'h00},     // tail after hit
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b1, 2'd2, CHAR_CR, CHAR_LF},
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b1, 2'd0, 8'h00, 8'h00},     // empty line
      // "ab", suffix
      '{ROW_CSR, CSR_PATTERN, 64'h6261, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_LENGTH,  64'h2,    8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h78, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h61, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h62, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h63, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      // "ab", prefix, then back to suffix in the middle of a matched line
      '{ROW_CSR, CSR_MODE, 64'h1, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h78, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h61, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h62, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h7A, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_MODE, 64'h0, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h71, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      // LF as pattern never hits
      '{ROW_CSR, CSR_PATTERN, 64'h0A, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_LENGTH,  64'h1,  8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h41, 8'd1, 1'b1, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b1, 2'd0, 8'h00, 8'h00},
      // length 0 acts as 1
      '{ROW_CSR, CSR_PATTERN, 64'h41, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_LENGTH,  64'h0,  8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h41, 8'd1, 1'b1, 2'd1, 8'h41, 8'h00},
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b1, 2'd2, CHAR_CR, CHAR_LF},
      // all-ones pattern, length 15 acts as 8, prefix; spare index is ignored
      '{ROW_CSR, CSR_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_LENGTH,  64'hF, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_MODE,    64'h1, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_CSR, CSR_SPARE,   64'h0, 8'd0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'hFF, 8'd8, 1'b0, 2'd0, 8'h00, 8'h00},
      '{ROW_BYTE, '0, 64'h0A, 8'd1, 1'b0, 2'd0, 8'h00, 8'h00}
   };

   // DUT signals
   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_in_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_line_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PAT_W-1:0]     csr_data;

   // Predictor copy of registers and line state, reset values
   logic [PAT_W-1:0]  pat_reg  = '0;
   logic [PLEN_W-1:0] len_reg  = 4'd1;
   logic              mode_reg = 1'b0;
   logic [WIN_W-1:0]  win      = '0;
   byte_type          line_mem [LINE_BYTES];
   int unsigned       fill     = 0;
   bit                matched  = 1'b0;

   cut_byte_type bytes_due [$];     // expected output, oldest first
   cut_byte_type step_bytes [$];    // output of the latest predicted byte

   int fault_count    = 0;
   int item_count     = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;       // receiver hold-off, counted down by the receiver

   line_pattern_cut_filter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_line_last (rsp_line_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Out-of-range lengths clamp into 1..PATTERN_BYTES.
   function automatic int unsigned active_len();
      if (len_reg == 0) return 1;
      if (len_reg > PATTERN_BYTES) return PATTERN_BYTES;
      return len_reg;
   endfunction

   // Newest stored byte lines up with the last pattern byte.
   function automatic bit window_hit(input int unsigned n);
      for (int unsigned k = 0; k < n; k++)
         if (win[8*k +: 8] != pat_reg[8*(n-1-k) +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   // Advance the line state by one byte; fills step_bytes with what it emits.
   function automatic void predict_cut(input byte_type b);
      int unsigned n;
      step_bytes.delete();
      if (b == CHAR_LF) begin
         if (matched) begin
            step_bytes.push_back({CHAR_CR, 1'b0});
            step_bytes.push_back({CHAR_LF, 1'b1});
         end
         fill    = 0;
         matched = 1'b0;
         win     = '0;
         return;
      end
      // long line: bytes past the buffer are dropped unseen
      if (fill >= LINE_BYTES) return;
      line_mem[fill] = b;
      fill++;
      win = {win[WIN_W-9:0], b};
      if (matched) begin
         if (!mode_reg) step_bytes.push_back({b, 1'b0});
         return;
      end
      n = active_len();
      if (fill >= n && window_hit(n)) begin
         matched = 1'b1;
         // suffix: just the pattern bytes; prefix: everything stored so far
         for (int unsigned i = mode_reg ? 0 : fill - n; i < fill; i++)
            step_bytes.push_back({line_mem[i], 1'b0});
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one byte; valid stays up afterwards so back-to-back bytes need no
   // second assignment in the same step. Anything else that burns cycles
   // drops valid first.
   task automatic send_byte(input byte_type b, input bit typed = 1'b0, input int n = 0,
                            input byte_type b0 = '0, input byte_type b1 = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      item_count++;
      predict_cut(b);
      if (typed) begin
         if (n > 0) bytes_due.push_back({b0, (b == CHAR_LF) && (n == 1)});
         if (n > 1) bytes_due.push_back({b1, b == CHAR_LF});
      end else begin
         foreach (step_bytes[i]) bytes_due.push_back(step_bytes[i]);
      end
      @(negedge clock);
   endtask

   // Stop sending, let every expected byte drain, then allow for trailing work.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One CSR transaction; leaves csr_valid high for a following write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN: pat_reg  = value;
         CSR_LENGTH:  len_reg  = value[PLEN_W-1:0];
         CSR_MODE:    mode_reg = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Full register set; unused upper data bits carry junk.
   task automatic configure(input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] len,
                            input logic mode);
      logic [PAT_W-1:0] junk;
      wait_idle();
      junk = {$urandom, $urandom};
      write_csr(CSR_PATTERN, pat);
      write_csr(CSR_LENGTH, {junk[PAT_W-1:PLEN_W], len});
      junk = {$urandom, $urandom};
      write_csr(CSR_MODE, {junk[PAT_W-1:1], mode});
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- random content

   function automatic logic [PAT_W-1:0] random_pattern();
      logic [PAT_W-1:0] p;
      for (int i = 0; i < PATTERN_BYTES; i++)
         case ($urandom_range(19))
            0:         p[8*i +: 8] = CHAR_LF;
            1, 2, 3:   p[8*i +: 8] = 8'($urandom_range(255));
            default:   p[8*i +: 8] = 8'h61 + 8'($urandom_range(3));
         endcase
      return p;
   endfunction

   function automatic logic [PLEN_W-1:0] random_length();
      case ($urandom_range(19))
         0:       return '0;
         1:       return PLEN_W'($urandom_range(9, 15));
         default: return PLEN_W'($urandom_range(1, $urandom_range(1) ? 3 : PATTERN_BYTES));
      endcase
   endfunction

   // Line byte biased toward pattern bytes so partial hits are common.
   function automatic byte_type pick_char();
      byte_type c;
      do begin
         case ($urandom_range(9))
            0, 1, 2, 3: c = pat_reg[8*$urandom_range(active_len() - 1) +: 8];
            4, 5, 6:    c = 8'h61 + 8'($urandom_range(3));
            default:    c = 8'($urandom_range(255));
         endcase
      end while (c == CHAR_LF);
      return c;
   endfunction

   // Well-formed line, mostly short, sometimes past the buffer, usually
   // carrying the pattern somewhere.
   task automatic send_text_line();
      byte_type    text [$];
      int unsigned len;
      int unsigned n;
      int unsigned pos;
      n   = active_len();
      len = ($urandom_range(7) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 16);
      for (int i = 0; i < len; i++) text.push_back(pick_char());
      if ($urandom_range(9) < 7 && len >= n) begin
         pos = $urandom_range(len - n);
         for (int k = 0; k < n; k++) text[pos + k] = pat_reg[8*k +: 8];
      end
      foreach (text[i]) send_byte(text[i]);
      send_byte(CHAR_LF);
   endtask

   task automatic run_phase(input int target);
      int start;
      start = item_count;
      while (item_count - start < target) begin
         if ($urandom_range(9) < 8) begin
            send_text_line();
         end else begin
            // noise: raw bytes, stray LFs, lines cut short or joined
            repeat ($urandom_range(1, 6))
               send_byte(($urandom_range(9) == 0) ? CHAR_LF : 8'($urandom_range(255)));
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver side

   // Stall changes on the falling edge; a requested hold-off wins over random stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Output check: sample on the rising edge, compare a little later so that
   // expectations pushed on the same edge are already queued.
   logic         seen_valid;
   byte_type     seen_byte;
   logic         seen_last;
   cut_byte_type want;

   always @(posedge clock) begin
      seen_valid = !reset && (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
      seen_byte  = rsp_out_byte;
      seen_last  = rsp_line_last;
      #1;
      if (seen_valid) begin
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected output transaction, expected none, actual %02h last %0b",
                     $time, seen_byte, seen_last);
            fault_count++;
         end else begin
            want = bytes_due.pop_front();
            if (want.data !== seen_byte || want.last !== seen_last) begin
               $display("%0t: output mismatch, expected %02h last %0b, actual %02h last %0b",
                        $time, want.data, want.last, seen_byte, seen_last);
               fault_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_pattern_cut_filter verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      req_valid   = 1'b0;
      req_in_byte = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_PATTERN;
      csr_data    = '0;
      reset       = 1'b1;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table; CSR rows only land while the block is idle
      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(DIRECTED[r].idx, DIRECTED[r].data);
            csr_valid <= 1'b0;
         end else begin
            repeat (DIRECTED[r].reps)
               send_byte(DIRECTED[r].data[7:0], DIRECTED[r].typed, DIRECTED[r].n,
                         DIRECTED[r].b0, DIRECTED[r].b1);
         end
      end

      // random phases, each with its own settings and idle pattern; phase
      // boundaries may fall mid-line after noise
      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct  = SEND_IDLE[ph];
         recv_stall_pct = RECV_STALL[ph];
         case (ph)
            0:       configure('1, 4'd8, 1'b1);
            1:       configure('0, 4'd1, 1'b0);
            default: configure(random_pattern(), random_length(),
                               (ph == HOLD_PHASE) ? 1'b1 : 1'($urandom_range(1)));
         endcase
         if (ph == HOLD_PHASE) hold_left = HOLD_CYCLES;
         if (ph == PAUSE_PHASE) begin
            run_phase(PHASE_ITEMS / 2);
            wait_idle();
            run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_phase(PHASE_ITEMS);
         end
      end

      wait_idle();
      if (bytes_due.size() != 0) begin
         $display("%0t: %0d expected output bytes never arrived", $time, bytes_due.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("line_pattern_cut_filter verification clean");
      else
         $display("line_pattern_cut_filter verification failed");
      $finish;
   end
endmodule
